FILE: sv/mfpr_pkg.sv
// ----------------------------------------------------------------------------
// mfpr_pkg
// Shared types and constants for the marker framed packet receiver.
// ----------------------------------------------------------------------------
package mfpr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MarkerW = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgAddrW = 1;

  localparam logic [MarkerW-1:0] StartMarkerRst = 32'hAA55_AA55;
  localparam logic [LenW-1:0]    MaxPayloadRst  = 16'hFFFF;

  // header field byte counts
  localparam logic [LenW-1:0] HdrFieldBytes = 16'd2;

  typedef enum logic [0:0] {
    CFG_START_MARKER = 1'b0,
    CFG_MAX_PAYLOAD  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_CSUM = 2'd2,
    PH_DATA = 2'd3
  } rx_phase_e;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_BYTE  = 2'd1,
    EV_END   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_BAD  = 2'd1,
    ST_LONG = 2'd2
  } frame_status_e;

  typedef struct packed {
    event_kind_e       event_kind;
    logic [ByteW-1:0]  payload_byte;
    logic              byte_valid;
    frame_status_e     frame_status;
  } result_t;

endpackage

FILE: sv/mfpr_core.sv
// ----------------------------------------------------------------------------
// mfpr_core
// Byte window, marker match, header/payload phase machine and checksum.
// ----------------------------------------------------------------------------
module mfpr_core
  import mfpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic [MarkerW-1:0] start_marker_i,
  input  logic [LenW-1:0]    max_payload_i,
  output logic               has_result_o,
  output result_t            result_o
);

  rx_phase_e        phase_q, phase_d;
  logic [MarkerW-1:0] window_q, window_d;
  logic [LenW-1:0]  frame_len_q, frame_len_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [SumW-1:0]  rx_sum_q, rx_sum_d;
  logic [SumW-1:0]  run_sum_q, run_sum_d;

  logic [MarkerW-1:0] window_sh;
  logic [LenW-1:0]    left_dec;
  logic [LenW-1:0]    len_sh;
  logic [SumW-1:0]    rx_sum_sh;
  logic [SumW-1:0]    run_sum_add;
  frame_status_e      chk_status;
  frame_status_e      chk_status_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      window_q    <= '0;
      frame_len_q <= '0;
      left_q      <= '0;
      rx_sum_q    <= '0;
      run_sum_q   <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      window_q    <= window_d;
      frame_len_q <= frame_len_d;
      left_q      <= left_d;
      rx_sum_q    <= rx_sum_d;
      run_sum_q   <= run_sum_d;
    end
  end

  assign window_sh   = {window_q[MarkerW-ByteW-1:0], rx_byte_i};
  assign left_dec    = left_q - LenW'(1);
  assign len_sh      = {frame_len_q[LenW-ByteW-1:0], rx_byte_i};
  assign rx_sum_sh   = {rx_sum_q[SumW-ByteW-1:0], rx_byte_i};
  assign run_sum_add = run_sum_q + SumW'(rx_byte_i);
  // sum of payload plus received checksum must wrap to zero
  assign chk_status      = ((run_sum_q + rx_sum_sh) == '0) ? ST_GOOD : ST_BAD;
  assign chk_status_data = ((run_sum_add + rx_sum_q) == '0) ? ST_GOOD : ST_BAD;

  always_comb begin
    phase_d      = phase_q;
    window_d     = window_sh;
    frame_len_d  = frame_len_q;
    left_d       = left_q;
    rx_sum_d     = rx_sum_q;
    run_sum_d    = run_sum_q;
    has_result_o = 1'b0;
    result_o     = '{event_kind: EV_START, payload_byte: '0, byte_valid: 1'b0,
                     frame_status: ST_GOOD};

    if (window_sh == start_marker_i) begin
      phase_d      = PH_LEN;
      window_d     = '0;
      frame_len_d  = '0;
      left_d       = HdrFieldBytes;
      rx_sum_d     = '0;
      run_sum_d    = '0;
      has_result_o = 1'b1;
    end else begin
      unique case (phase_q)
        PH_LEN: begin
          frame_len_d = len_sh;
          left_d      = left_dec;
          if (left_dec == '0) begin
            if (len_sh > max_payload_i) begin
              phase_d      = PH_IDLE;
              window_d     = '0;
              frame_len_d  = '0;
              left_d       = '0;
              rx_sum_d     = '0;
              run_sum_d    = '0;
              has_result_o = 1'b1;
              result_o.event_kind   = EV_END;
              result_o.frame_status = ST_LONG;
            end else begin
              phase_d = PH_CSUM;
              left_d  = HdrFieldBytes;
            end
          end
        end
        PH_CSUM: begin
          rx_sum_d = rx_sum_sh;
          left_d   = left_dec;
          if (left_dec == '0) begin
            if (frame_len_q != '0) begin
              phase_d = PH_DATA;
              left_d  = frame_len_q;
            end else begin
              phase_d      = PH_IDLE;
              has_result_o = 1'b1;
              result_o.event_kind   = EV_END;
              result_o.frame_status = chk_status;
            end
          end
        end
        PH_DATA: begin
          run_sum_d    = run_sum_add;
          left_d       = left_dec;
          has_result_o = 1'b1;
          result_o.payload_byte = rx_byte_i;
          result_o.byte_valid   = 1'b1;
          if (left_dec == '0) begin
            phase_d = PH_IDLE;
            result_o.event_kind   = EV_END;
            result_o.frame_status = chk_status_data;
          end else begin
            result_o.event_kind = EV_BYTE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/mfpr_out.sv
// ----------------------------------------------------------------------------
// mfpr_out
// Result register; holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mfpr_out
  import mfpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    has_result_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    can_load_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = has_result_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && has_result_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

FILE: sv/marker_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver
// Byte stream deframer: start marker search, length/checksum header,
// payload streaming and sum checksum check at frame end.
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  input   | in_valid_i, in_ready_o, rx_byte_i          | request in
//  output  | out_valid_o, out_ready_i, event_kind_o,    | request out
//          | payload_byte_o, byte_valid_o, frame_status_o |
//  config  | cfg_we_i, cfg_addr_i, cfg_wdata_i          | write only
//
// One byte per cycle while in_ready_o is high; the result register is
// loaded in the cycle the byte is accepted and is visible on the next cycle.
// in_ready_o is high when the result register is empty or being taken.
// Reset returns the phase to idle, clears the window and sums, and loads
// the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
module marker_framed_packet_receiver
  import mfpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic               byte_valid_o,
  output logic [1:0]         frame_status_o,
  input  logic               cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [MarkerW-1:0] cfg_wdata_i
);

  logic [MarkerW-1:0] start_marker_q;
  logic [LenW-1:0]    max_payload_q;
  logic               step;
  logic               has_result;
  result_t            core_result;
  result_t            out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      max_payload_q  <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_START_MARKER: start_marker_q <= cfg_wdata_i;
        CFG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign step = in_valid_i && in_ready_o;

  mfpr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .rx_byte_i      (rx_byte_i),
    .start_marker_i (start_marker_q),
    .max_payload_i  (max_payload_q),
    .has_result_o   (has_result),
    .result_o       (core_result)
  );

  mfpr_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .has_result_i (has_result),
    .result_i     (core_result),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .can_load_o   (in_ready_o),
    .result_o     (out_result)
  );

  assign event_kind_o   = out_result.event_kind;
  assign payload_byte_o = out_result.payload_byte;
  assign byte_valid_o   = out_result.byte_valid;
  assign frame_status_o = out_result.frame_status;

endmodule

FILE: verif/marker_framed_packet_receiver_test.sv
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver_test
// Self-checking bench for the deframer. Bytes go in on a valid/ready request
// channel and every event coming out is compared with a local model of the
// marker search, header phases and sum checksum. Directed frames cover empty,
// good, bad, over-limit and interrupted frames and register extremes. Random
// phases then run mostly well-formed frames under changing settings, bursty
// input and a stalling output.
// ----------------------------------------------------------------------------
module marker_framed_packet_receiver_test;
  import mfpr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic [ByteW-1:0]    rx_byte = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [MarkerW-1:0]  cfg_wdata = '0;

  logic             in_ready;
  logic             out_valid;
  logic [1:0]       event_kind;
  logic [ByteW-1:0] payload_byte;
  logic             byte_valid;
  logic [1:0]       frame_status;

  marker_framed_packet_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_kind_o   (event_kind),
    .payload_byte_o (payload_byte),
    .byte_valid_o   (byte_valid),
    .frame_status_o (frame_status),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // deframer model state
  rx_phase_e          ph;
  logic [MarkerW-1:0] win;
  logic [LenW-1:0]    flen;
  logic [LenW-1:0]    fleft;
  logic [SumW-1:0]    rsum;
  logic [SumW-1:0]    psum;
  logic [MarkerW-1:0] marker_cfg;
  logic [LenW-1:0]    limit_cfg;

  result_t expected_events[$];

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  events_checked = 0;
  int  frame_ends = 0;
  int  cycle_count = 0;
  bit  sender_gaps = 1'b0;
  int  burst_left = 0;
  int  rx_stall_mode = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  pat_pos = 0;
  logic [31:0] stall_pattern = '1;

  function automatic void frame_clear();
    ph    = PH_IDLE;
    win   = '0;
    flen  = '0;
    fleft = '0;
    rsum  = '0;
    psum  = '0;
  endfunction

  function automatic result_t make_event(event_kind_e kind, logic [7:0] b, logic v,
                                         frame_status_e st);
    result_t ev;
    ev.event_kind   = kind;
    ev.payload_byte = b;
    ev.byte_valid   = v;
    ev.frame_status = st;
    return ev;
  endfunction

  function automatic frame_status_e sum_status();
    logic [SumW-1:0] neg;
    neg = ~psum + 16'd1;
    return (neg == rsum) ? ST_GOOD : ST_BAD;
  endfunction

  // returns 1 when the byte produces an event
  function automatic bit deframe_byte(input logic [7:0] x, output result_t ev);
    ev  = make_event(EV_START, 8'h00, 1'b0, ST_GOOD);
    win = {win[23:0], x};
    if (win == marker_cfg) begin
      frame_clear();
      ph    = PH_LEN;
      fleft = HdrFieldBytes;
      return 1'b1;
    end
    case (ph)
      PH_LEN: begin
        flen  = {flen[7:0], x};
        fleft = fleft - 16'd1;
        if (fleft == 0) begin
          if (flen > limit_cfg) begin
            frame_clear();
            ev = make_event(EV_END, 8'h00, 1'b0, ST_LONG);
            return 1'b1;
          end
          ph    = PH_CSUM;
          fleft = HdrFieldBytes;
        end
        return 1'b0;
      end
      PH_CSUM: begin
        rsum  = {rsum[7:0], x};
        fleft = fleft - 16'd1;
        if (fleft == 0) begin
          if (flen != 0) begin
            ph    = PH_DATA;
            fleft = flen;
          end else begin
            ph = PH_IDLE;
            ev = make_event(EV_END, 8'h00, 1'b0, sum_status());
            return 1'b1;
          end
        end
        return 1'b0;
      end
      PH_DATA: begin
        psum  = psum + 16'(x);
        fleft = fleft - 16'd1;
        if (fleft == 0) begin
          ph = PH_IDLE;
          ev = make_event(EV_END, x, 1'b1, sum_status());
        end else begin
          ev = make_event(EV_BYTE, x, 1'b1, ST_GOOD);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    result_t ev;
    if (sender_gaps && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (deframe_byte(b, ev)) expected_events.insert(expected_events.size(), ev);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  task automatic send_marker();
    send_word(marker_cfg[31:16]);
    send_word(marker_cfg[15:0]);
  endtask

  task automatic send_frame(input logic [15:0] len, input int body_len, input bit sum_ok);
    logic [7:0]  body[$];
    logic [15:0] sum;
    logic [15:0] csum;
    int i;
    sum = '0;
    for (i = 0; i < body_len; i++) begin
      body.insert(body.size(), 8'($urandom_range(0, 255)));
      sum = sum + 16'(body[i]);
    end
    csum = sum_ok ? (~sum + 16'd1) : 16'($urandom);
    send_marker();
    send_word(len);
    send_word(csum);
    foreach (body[k]) send_byte(body[k]);
  endtask

  task automatic wait_for_quiet();
    in_valid = 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_START_MARKER: marker_cfg = val;
      CFG_MAX_PAYLOAD:  limit_cfg  = val[15:0];
      default: ;
    endcase
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (rx_stall_mode == 0) begin
      out_ready = 1'b1;
    end else begin
      if (pat_pos == 0) stall_pattern = $urandom | $urandom;
      out_ready = stall_pattern[pat_pos];
      pat_pos   = (pat_pos + 1) % 32;
    end
  end

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t ev;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d byte %0d valid %0d status %0d",
               event_kind, payload_byte, byte_valid, frame_status);
        fail_count++;
      end else begin
        ev = expected_events.pop_front();
        check_field("event_kind", ev.event_kind, event_kind);
        check_field("payload_byte", ev.payload_byte, payload_byte);
        check_field("byte_valid", ev.byte_valid, byte_valid);
        check_field("frame_status", ev.frame_status, frame_status);
        events_checked++;
        if (event_kind == EV_END) frame_ends++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed_frames();
    rx_stall_mode = 0;
    sender_gaps   = 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty frame, good sum
    send_marker();
    send_word(16'h0000);
    send_word(16'h0000);
    // two bytes, sum 0x100
    send_marker();
    send_word(16'h0002);
    send_word(16'hFF00);
    send_byte(8'hFF);
    send_byte(8'h01);
    // one byte, bad sum
    send_marker();
    send_word(16'h0001);
    send_word(16'h0000);
    send_byte(8'h80);
    wait_for_quiet();
  endtask

  task automatic test_length_limit();
    cfg_write(CFG_MAX_PAYLOAD, 32'd4);
    send_marker();
    send_word(16'h0005);
    send_frame(16'd4, 4, 1'b1);
    wait_for_quiet();
    // limit changed between the two length bytes
    send_marker();
    send_byte(8'h00);
    wait_for_quiet();
    cfg_write(CFG_MAX_PAYLOAD, 32'd0);
    send_byte(8'h01);
    wait_for_quiet();
    cfg_write(CFG_MAX_PAYLOAD, 32'h0000_FFFE);
    send_marker();
    send_word(16'hFFFF);
    wait_for_quiet();
    cfg_write(CFG_MAX_PAYLOAD, {16'h0, MaxPayloadRst});
  endtask

  task automatic test_marker_in_frame();
    send_frame(16'd10, 3, 1'b1);
    send_frame(16'd2, 2, 1'b1);
    send_frame(16'hFFFF, 5, 1'b0);
    send_frame(16'd0, 0, 1'b1);
    wait_for_quiet();
  endtask

  task automatic test_register_extremes();
    cfg_write(CFG_START_MARKER, 32'hFFFF_FFFF);
    cfg_write(CFG_MAX_PAYLOAD, 32'd0);
    send_frame(16'd0, 0, 1'b1);
    send_frame(16'd1, 1, 1'b1);
    send_byte(8'h5A);
    wait_for_quiet();
    cfg_write(CFG_START_MARKER, 32'h0000_0000);
    cfg_write(CFG_MAX_PAYLOAD, 32'h0000_FFFF);
    send_frame(16'd3, 3, 1'b1);
    send_frame(16'h0102, 4, 1'b1);
    wait_for_quiet();
    cfg_write(CFG_START_MARKER, StartMarkerRst);
  endtask

  task automatic test_backpressure();
    rx_stall_mode = 0;
    sender_gaps   = 1'b0;
    hold_req      = 1'b1;
    send_frame(16'd40, 40, 1'b1);
    wait_for_quiet();
  endtask

  task automatic run_random_phase(input logic [31:0] marker, input logic [15:0] limit,
                                  input int stall_mode, input bit gaps, input int budget);
    int stop_at;
    int pick;
    logic [15:0] len;
    int body_len;
    cfg_write(CFG_START_MARKER, marker);
    cfg_write(CFG_MAX_PAYLOAD, {16'h0, limit});
    rx_stall_mode = stall_mode;
    sender_gaps   = gaps;
    stop_at       = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 70) len = 16'($urandom_range(0, 12));
      else if (pick < 85) len = 16'($urandom_range(13, 48));
      else if (pick < 93) len = 16'($urandom_range(0, 65535));
      else len = (limit == 16'hFFFF) ? 16'($urandom_range(0, 6)) : limit + 16'd1;
      if (len > limit) body_len = $urandom_range(0, 2);
      else if (len > 48) body_len = $urandom_range(0, 48);
      else if ($urandom_range(0, 9) == 0) body_len = $urandom_range(0, len);
      else body_len = len;
      send_frame(len, body_len, $urandom_range(0, 6) != 0);
    end
    wait_for_quiet();
  endtask

  task automatic test_random_traffic();
    run_random_phase(StartMarkerRst, MaxPayloadRst, 1, 1'b1, 240);
    run_random_phase($urandom, 16'($urandom_range(8, 40)), 1, 1'b1, 200);
    run_random_phase($urandom, MaxPayloadRst, 0, 1'b0, 160);
    run_random_phase(32'hFFFF_FFFF, 16'd0, 1, 1'b1, 80);
    run_random_phase($urandom, 16'($urandom_range(0, 20)), 1, 1'b0, 160);
    run_random_phase(32'h0000_0000, 16'd12, 1, 1'b1, 80);
  endtask

  initial begin
    frame_clear();
    marker_cfg = StartMarkerRst;
    limit_cfg  = MaxPayloadRst;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_length_limit();
    test_marker_in_frame();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_for_quiet();
    $display("Sent %0d bytes, checked %0d events including %0d frame ends",
             bytes_sent, events_checked, frame_ends);
    $display("Covered empty, bad-sum, over-limit and interrupted frames, extreme settings");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mfpr_pkg.sv
sv/mfpr_core.sv
sv/mfpr_out.sv
sv/marker_framed_packet_receiver.sv
verif/marker_framed_packet_receiver_test.sv
